FILE: sv/svzt_pkg.sv
// ----------------------------------------------------------------------------
// svzt_pkg
// Shared types and constants for the speeding vehicle zone tracker.
// ----------------------------------------------------------------------------
package svzt_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  localparam int ID_W    = 32;
  localparam int ZONE_W  = 8;
  localparam int SPEED_W = 12;
  localparam int TIME_W  = 32;
  localparam int MSG_W   = 2;
  localparam int CNT_W   = 6;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 2;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SNAP        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_LOADED  = 2'd3;

  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

  // sign messages
  localparam logic [MSG_W-1:0] MSG_BLANK = 2'd0;
  localparam logic [MSG_W-1:0] MSG_CURVE = 2'd3;

  // zones that raise the curve warning
  localparam logic [ZONE_W-1:0] WARN_ZONE_LO = 8'd1;
  localparam logic [ZONE_W-1:0] WARN_ZONE_HI = 8'd3;

  typedef struct packed {
    logic [ID_W-1:0]    vehicle;
    logic [ZONE_W-1:0]  zone;
    logic [SPEED_W-1:0] speed;
    logic [TIME_W-1:0]  stamp;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_TAIL,
    ST_UPDATE,
    ST_SWEEP,
    ST_SWEEP_TAIL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;    // capture the item, clear accumulators
    logic issue;   // read table at the address counter, advance
    logic sweep;   // returned data feeds aging/scoring instead of lookup
    logic update;  // insert, overwrite or erase the looked-up entry
    logic finish;  // build the result and load the output register
  } cmd_t;

  typedef struct packed {
    logic map_loaded;
    logic last_addr;
    logic out_free;
  } status_t;

endpackage

FILE: sv/speeding_vehicle_zone_tracker.sv
// ----------------------------------------------------------------------------
// speeding_vehicle_zone_tracker
// Tracks vehicles by id, ages out silent ones and picks the curve warning
// message from the lowest zone that holds a speeding vehicle.
// ----------------------------------------------------------------------------
//  Port group     Handshake              Payload
//  in             in_valid / in_ready    vehicle_id, zone_number,
//                                        speed_tenths_mph, time_ms
//  out            out_valid / out_ready  sign_message, message_changed,
//                                        top_zone, table_full, vehicle_count
//  cfg            cfg_wr_en              cfg_index, cfg_data
//
//  Each item runs a lookup pass and an aging/scoring pass, each one table read
//  per cycle through the single read port of the table RAM, plus load,
//  update and finish cycles.
//  Items arriving with map_loaded clear are taken and dropped, no result.
//  Reset (rst, synchronous) clears all valid bits and the sent-message history
//  and returns the configuration registers to their reset values (timeout
//  1000 ms, others 0); the table data itself is not cleared.
//  A stalled result stays in the output register while the next item runs;
//  that item then waits in its last cycle until the register is free.
// ----------------------------------------------------------------------------
module speeding_vehicle_zone_tracker import svzt_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic signed [ID_W-1:0] vehicle_id,
  input  logic [ZONE_W-1:0]      zone_number,
  input  logic [SPEED_W-1:0]     speed_tenths_mph,
  input  logic [TIME_W-1:0]      time_ms,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [MSG_W-1:0]       sign_message,
  output logic                   message_changed,
  output logic [ZONE_W-1:0]      top_zone,
  output logic                   table_full,
  output logic [CNT_W-1:0]       vehicle_count
);

  cmd_t    cmd;
  status_t status;

  svzt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  svzt_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .vehicle_id       (vehicle_id),
    .zone_number      (zone_number),
    .speed_tenths_mph (speed_tenths_mph),
    .time_ms          (time_ms),
    .cmd              (cmd),
    .status           (status),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .sign_message     (sign_message),
    .message_changed  (message_changed),
    .top_zone         (top_zone),
    .table_full       (table_full),
    .vehicle_count    (vehicle_count)
  );

endmodule

FILE: sv/svzt_ram.sv
// ----------------------------------------------------------------------------
// svzt_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module svzt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/svzt_dp.sv
// ----------------------------------------------------------------------------
// svzt_dp
// Datapath: configuration registers, vehicle table, valid bits, lookup,
// aging and scoring accumulators, and the result register.
// ----------------------------------------------------------------------------
module svzt_dp import svzt_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  input  logic signed [ID_W-1:0]   vehicle_id,
  input  logic [ZONE_W-1:0]        zone_number,
  input  logic [SPEED_W-1:0]       speed_tenths_mph,
  input  logic [TIME_W-1:0]        time_ms,
  input  cmd_t                     cmd,
  output status_t                  status,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [MSG_W-1:0]         sign_message,
  output logic                     message_changed,
  output logic [ZONE_W-1:0]        top_zone,
  output logic                     table_full,
  output logic [CNT_W-1:0]         vehicle_count
);

  // configuration
  logic [7:0]  speed_limit;
  logic [15:0] snap_interval;
  logic [15:0] timeout;
  logic        map_loaded;

  // captured item
  logic [ID_W-1:0]    id_q;
  logic [ZONE_W-1:0]  zone_q;
  logic [SPEED_W-1:0] speed_q;
  logic [TIME_W-1:0]  now_q;

  // table control
  logic [TABLE_DEPTH-1:0] valid;
  logic [TABLE_DEPTH-1:0] valid_next;
  logic [IDX_W-1:0]       addr;
  logic                   rd_vld;
  logic [IDX_W-1:0]       rd_idx;
  logic [ENTRY_W-1:0]     rd_data;
  entry_t                 rd_entry;
  entry_t                 wr_entry;
  logic                   we;
  logic [IDX_W-1:0]       waddr;

  // accumulators
  logic               hit_found;
  logic [IDX_W-1:0]   hit_idx;
  logic [TIME_W-1:0]  hit_stamp;
  logic               free_found;
  logic [IDX_W-1:0]   free_idx;
  logic               full;
  logic [ZONE_W-1:0]  top;
  logic [CNT_W-1:0]   count;

  logic               sent_any;
  logic [MSG_W-1:0]   last_msg;

  logic               rd_v;
  logic [TIME_W-1:0]  sweep_age;
  logic               stale;
  logic [TIME_W-1:0]  hit_age;
  logic               erase;
  logic               insert;
  logic [SPEED_W-1:0] limit_tenths;
  logic               speeding;
  logic [MSG_W-1:0]   msg;
  logic               scan_eval;
  logic               sweep_eval;

  svzt_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wr_entry),
    .raddr (addr),
    .rdata (rd_data)
  );

  assign rd_entry     = entry_t'(rd_data);
  assign rd_v         = valid[rd_idx];
  assign scan_eval    = rd_vld && !cmd.sweep;
  assign sweep_eval   = rd_vld && cmd.sweep;
  assign sweep_age    = now_q - rd_entry.stamp;
  assign stale        = sweep_age > {16'd0, timeout};
  assign hit_age      = now_q - hit_stamp;
  assign erase        = (zone_q == '0) && (hit_age < {16'd0, snap_interval});
  assign insert       = !hit_found && (zone_q != '0) && free_found;
  assign limit_tenths = (SPEED_W'(speed_limit) << 3) + (SPEED_W'(speed_limit) << 1);
  assign speeding     = (rd_entry.zone != '0) && (rd_entry.speed > limit_tenths);

  assign we       = cmd.update && (insert || (hit_found && !erase));
  assign waddr    = hit_found ? hit_idx : free_idx;
  assign wr_entry = '{vehicle: id_q, zone: zone_q, speed: speed_q, stamp: now_q};

  assign msg = ((top >= WARN_ZONE_LO) && (top <= WARN_ZONE_HI)) ? MSG_CURVE : MSG_BLANK;

  assign status.map_loaded = map_loaded;
  assign status.last_addr  = (addr == IDX_W'(TABLE_DEPTH - 1));
  assign status.out_free   = !out_valid || out_ready;

  always_comb begin
    valid_next = valid;
    if (cmd.update) begin
      if (hit_found && erase) begin
        valid_next[hit_idx] = 1'b0;
      end else if (insert) begin
        valid_next[free_idx] = 1'b1;
      end
    end
    if (sweep_eval && rd_v && stale) begin
      valid_next[rd_idx] = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      speed_limit   <= '0;
      snap_interval <= '0;
      timeout       <= TIMEOUT_RESET;
      map_loaded    <= 1'b0;
      valid         <= '0;
      rd_vld        <= 1'b0;
      out_valid     <= 1'b0;
      sent_any      <= 1'b0;
      last_msg      <= MSG_BLANK;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_SPEED_LIMIT: speed_limit   <= cfg_data[7:0];
          REG_SNAP:        snap_interval <= cfg_data;
          REG_TIMEOUT:     timeout       <= cfg_data;
          REG_MAP_LOADED:  map_loaded    <= cfg_data[0];
        endcase
      end
      valid  <= valid_next;
      rd_vld <= cmd.issue;
      if (cmd.finish) begin
        out_valid <= 1'b1;
        sent_any  <= 1'b1;
        last_msg  <= msg;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload and per-item accumulators
  always_ff @(posedge clk) begin
    rd_idx <= addr;
    if (cmd.load) begin
      id_q       <= $unsigned(vehicle_id);
      zone_q     <= zone_number;
      speed_q    <= speed_tenths_mph;
      now_q      <= time_ms;
      addr       <= '0;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
      full       <= 1'b0;
      top        <= '0;
      count      <= '0;
    end else if (cmd.update) begin
      addr <= '0;
      if (!hit_found && (zone_q != '0) && !free_found) begin
        full <= 1'b1;
      end
    end else if (cmd.issue) begin
      addr <= addr + 1'b1;
    end

    // lookup: first matching valid entry, first free slot
    if (scan_eval) begin
      if (rd_v && !hit_found && (rd_entry.vehicle == id_q)) begin
        hit_found <= 1'b1;
        hit_idx   <= rd_idx;
        hit_stamp <= rd_entry.stamp;
      end
      if (!rd_v && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= rd_idx;
      end
    end

    // aging and scoring; a speeding entry has a nonzero zone, so top of 0 means none yet
    if (sweep_eval && rd_v && !stale) begin
      count <= count + 1'b1;
      if (speeding && ((top == '0) || (rd_entry.zone < top))) begin
        top <= rd_entry.zone;
      end
    end

    if (cmd.finish) begin
      sign_message    <= msg;
      message_changed <= !sent_any || (msg != last_msg);
      top_zone        <= top;
      table_full      <= full;
      vehicle_count   <= count;
    end
  end

  a_count_matches_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (count == CNT_W'($countones(valid))))
    else $error("entry count disagrees with valid bits");

  a_msg_from_zone: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((sign_message == MSG_CURVE) ==
                   ((top_zone >= WARN_ZONE_LO) && (top_zone <= WARN_ZONE_HI))))
    else $error("sign message inconsistent with top zone");

  a_update_drained: assert property (@(posedge clk) disable iff (rst)
    cmd.update |-> (!rd_vld && !cmd.issue))
    else $error("table update overlaps a read");

  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!out_valid || out_ready))
    else $error("result overwritten before it was taken");

endmodule

FILE: sv/svzt_ctrl.sv
// ----------------------------------------------------------------------------
// svzt_ctrl
// Controller: sequences lookup pass, table update, aging/scoring pass and
// result hand-off.
// ----------------------------------------------------------------------------
module svzt_ctrl import svzt_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        // drop the item without a result while no map is loaded
        if (in_valid && status.map_loaded) begin
          cmd.load   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.issue = 1'b1;
        if (status.last_addr) begin
          state_next = ST_SCAN_TAIL;
        end
      end
      ST_SCAN_TAIL: begin
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = ST_SWEEP;
      end
      ST_SWEEP: begin
        cmd.issue = 1'b1;
        cmd.sweep = 1'b1;
        if (status.last_addr) begin
          state_next = ST_SWEEP_TAIL;
        end
      end
      ST_SWEEP_TAIL: begin
        cmd.sweep  = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        // hold until the output register is free
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_load_only_loaded: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (in_valid && status.map_loaded))
    else $error("item loaded without a loaded map");

  a_update_after_scan: assert property (@(posedge clk) disable iff (rst)
    cmd.update |-> ($past(state) == ST_SCAN_TAIL))
    else $error("update without a completed lookup pass");

  a_finish_after_sweep: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !$past(cmd.issue))
    else $error("result built while aging pass still running");

endmodule

FILE: sim/zone_sign_checker.sv
// ----------------------------------------------------------------------------
// zone_sign_checker
// Watches the config port and both item channels of the speeding vehicle
// zone tracker, keeps its own vehicle table and sign history, predicts the
// result of every accepted report and compares it field by field with the
// results the block hands out, in order.
// ----------------------------------------------------------------------------
module zone_sign_checker import svzt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [ID_W-1:0]      vehicle_id,
  input  logic [ZONE_W-1:0]    zone_number,
  input  logic [SPEED_W-1:0]   speed_tenths_mph,
  input  logic [TIME_W-1:0]    time_ms,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [MSG_W-1:0]     sign_message,
  input  logic                 message_changed,
  input  logic [ZONE_W-1:0]    top_zone,
  input  logic                 table_full,
  input  logic [CNT_W-1:0]     vehicle_count,
  output int                   fail_count,
  output int                   pending_signs
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [MSG_W-1:0]  msg;
    logic              changed;
    logic [ZONE_W-1:0] top;
    logic              full;
    logic [CNT_W-1:0]  count;
  } sign_t;

  logic               tracked    [TABLE_DEPTH];
  logic [ID_W-1:0]    trk_id     [TABLE_DEPTH];
  logic [ZONE_W-1:0]  trk_zone   [TABLE_DEPTH];
  logic [SPEED_W-1:0] trk_speed  [TABLE_DEPTH];
  logic [TIME_W-1:0]  trk_stamp  [TABLE_DEPTH];

  logic [7:0]         limit_mph;
  logic [15:0]        snap_ms;
  logic [15:0]        timeout_ms;
  logic               map_on;
  logic               sent_any;
  logic [MSG_W-1:0]   last_msg;

  sign_t              expected_signs [$];
  sign_t              want;
  int                 errors = 0;

  assign fail_count = errors;

  function automatic sign_t track_report(input logic [ID_W-1:0]    id,
                                         input logic [ZONE_W-1:0]  zone,
                                         input logic [SPEED_W-1:0] speed,
                                         input logic [TIME_W-1:0]  now);
    int                hit;
    int                free_slot;
    int                count;
    logic              full;
    logic              found;
    logic [ZONE_W-1:0] top;
    logic [31:0]       limit_tenths;
    logic [TIME_W-1:0] age;
    sign_t             r;
    hit = -1;
    free_slot = -1;
    count = 0;
    full = 1'b0;
    found = 1'b0;
    top = '0;
    limit_tenths = 32'(limit_mph) * 32'd10;

    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (tracked[i]) begin
        if (hit < 0 && trk_id[i] == id) hit = i;
      end else if (free_slot < 0) begin
        free_slot = i;
      end
    end

    if (hit < 0) begin
      // unknown vehicle outside all zones is not tracked
      if (zone != '0) begin
        if (free_slot < 0) begin
          full = 1'b1;
        end else begin
          tracked[free_slot]   = 1'b1;
          trk_id[free_slot]    = id;
          trk_zone[free_slot]  = zone;
          trk_speed[free_slot] = speed;
          trk_stamp[free_slot] = now;
        end
      end
    end else begin
      age = now - trk_stamp[hit];
      if (zone == '0 && age < TIME_W'(snap_ms)) begin
        tracked[hit] = 1'b0;
      end else begin
        trk_zone[hit]  = zone;
        trk_speed[hit] = speed;
        trk_stamp[hit] = now;
      end
    end

    // drop silent vehicles
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      age = now - trk_stamp[i];
      if (tracked[i] && age > TIME_W'(timeout_ms)) tracked[i] = 1'b0;
    end

    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (tracked[i]) begin
        count++;
        if (trk_zone[i] != '0 && 32'(trk_speed[i]) > limit_tenths &&
            (!found || trk_zone[i] < top)) begin
          top = trk_zone[i];
          found = 1'b1;
        end
      end
    end

    r.msg     = (top >= WARN_ZONE_LO && top <= WARN_ZONE_HI) ? MSG_CURVE : MSG_BLANK;
    r.changed = !sent_any || (r.msg != last_msg);
    r.top     = top;
    r.full    = full;
    r.count   = CNT_W'(count);
    sent_any  = 1'b1;
    last_msg  = r.msg;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TABLE_DEPTH; i++) tracked[i] = 1'b0;
      limit_mph  = '0;
      snap_ms    = '0;
      timeout_ms = TIMEOUT_RESET;
      map_on     = 1'b0;
      sent_any   = 1'b0;
      last_msg   = MSG_BLANK;
      expected_signs.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_signs.size() == 0) begin
          $error("result item with none expected: top_zone %0d, vehicle_count %0d",
                 top_zone, vehicle_count);
          errors++;
        end else begin
          want = expected_signs.pop_front();
          check_field("sign_message", 32'(want.msg), 32'(sign_message));
          check_field("message_changed", 32'(want.changed), 32'(message_changed));
          check_field("top_zone", 32'(want.top), 32'(top_zone));
          check_field("table_full", 32'(want.full), 32'(table_full));
          check_field("vehicle_count", 32'(want.count), 32'(vehicle_count));
        end
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_SPEED_LIMIT: limit_mph  = cfg_data[7:0];
          REG_SNAP:        snap_ms    = cfg_data;
          REG_TIMEOUT:     timeout_ms = cfg_data;
          REG_MAP_LOADED:  map_on     = cfg_data[0];
          default: ;
        endcase
      end
      // reports taken while the map is not loaded give no result
      if (in_valid && in_ready && map_on)
        expected_signs.push_back(track_report(vehicle_id, zone_number,
                                              speed_tenths_mph, time_ms));
    end
    pending_signs <= expected_signs.size();
  end

  final begin
    if (expected_signs.size() != 0)
      $error("%0d result items never arrived", expected_signs.size());
  end

endmodule

FILE: sim/speeding_vehicle_zone_tracker_tb.sv
// ----------------------------------------------------------------------------
// speeding_vehicle_zone_tracker_tb
// Drives vehicle reports into the zone tracker: a directed pass over the
// insert, erase, overwrite, aging, wrap and limit corners, then random
// phases with varied settings, id pools and time steps, under changing
// sender gaps and receiver stalls. The checker beside the block predicts
// and compares every result item.
// ----------------------------------------------------------------------------
module speeding_vehicle_zone_tracker_tb;
  import svzt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [ID_W-1:0] ID_MIN  = 32'h8000_0000;
  localparam logic [ID_W-1:0] ID_MAX  = 32'h7fff_ffff;
  localparam logic [ID_W-1:0] ID_ZERO = 32'h0000_0000;
  localparam logic [ID_W-1:0] ID_ONES = 32'hffff_ffff;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]       cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic signed [ID_W-1:0] vehicle_id = '0;
  logic [ZONE_W-1:0]      zone_number = '0;
  logic [SPEED_W-1:0]     speed_tenths_mph = '0;
  logic [TIME_W-1:0]      time_ms = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [MSG_W-1:0]       sign_message;
  logic                   message_changed;
  logic [ZONE_W-1:0]      top_zone;
  logic                   table_full;
  logic [CNT_W-1:0]       vehicle_count;
  int                     fail_count;
  int                     pending_signs;

  int                     send_idle_pct = 0;
  int                     stall_pct = 0;
  int                     cur_limit = 0;
  int                     cur_snap = 0;
  int                     cur_timeout = 1000;
  logic [TIME_W-1:0]      now_ms = '0;
  logic [ID_W-1:0]        id_pool [48];
  int                     pool_n = 1;

  speeding_vehicle_zone_tracker u_top (
    .clk, .rst, .cfg_wr_en, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .vehicle_id, .zone_number, .speed_tenths_mph, .time_ms,
    .out_valid, .out_ready, .sign_message, .message_changed, .top_zone,
    .table_full, .vehicle_count
  );

  zone_sign_checker u_checker (
    .clk, .rst, .cfg_wr_en, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .vehicle_id, .zone_number, .speed_tenths_mph, .time_ms,
    .out_valid, .out_ready, .sign_message, .message_changed, .top_zone,
    .table_full, .vehicle_count, .fail_count, .pending_signs
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else     out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  initial begin
    #3000000;
    $display("speeding_vehicle_zone_tracker: mismatch");
    $finish;
  end

  // Hold the item until it is taken; valid stays up if the next one follows.
  task automatic send_report(input logic [ID_W-1:0] id, input logic [ZONE_W-1:0] zone,
                             input logic [SPEED_W-1:0] speed,
                             input logic [TIME_W-1:0] stamp);
    if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid         <= 1'b1;
    vehicle_id       <= id;
    zone_number      <= zone;
    speed_tenths_mph <= speed;
    time_ms          <= stamp;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drain all results, then give the block time to finish an item that
  // produces none.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_signs != 0) @(posedge clk);
    repeat (2 * TABLE_DEPTH + 16) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  task automatic configure(input logic [7:0] limit, input logic [15:0] snap,
                           input logic [15:0] timeout, input logic map);
    write_reg(REG_SPEED_LIMIT, {8'd0, limit});
    write_reg(REG_SNAP, snap);
    write_reg(REG_TIMEOUT, timeout);
    write_reg(REG_MAP_LOADED, {15'd0, map});
    cfg_wr_en   <= 1'b0;
    cur_limit   = limit;
    cur_snap    = snap;
    cur_timeout = timeout;
  endtask

  task automatic random_report();
    int                r;
    int                s;
    logic [ID_W-1:0]   id;
    logic [ZONE_W-1:0] zone;
    logic [TIME_W-1:0] step;
    id = ($urandom_range(0, 99) < 90) ? id_pool[$urandom_range(0, pool_n - 1)] : $urandom();
    r = $urandom_range(0, 99);
    if (r < 20)      zone = '0;
    else if (r < 80) zone = ZONE_W'($urandom_range(1, 5));
    else             zone = ZONE_W'($urandom_range(0, 255));
    // keep many speeds right around the limit
    if ($urandom_range(0, 1) == 0) begin
      s = cur_limit * 10 + $urandom_range(0, 10) - 5;
      if (s < 0) s = 0;
      if (s > 4095) s = 4095;
    end else begin
      s = $urandom_range(0, 4095);
    end
    r = $urandom_range(0, 99);
    if (r < 60)      step = $urandom_range(0, 40);
    else if (r < 85) step = $urandom_range(0, cur_snap);
    else if (r < 97) step = $urandom_range(0, cur_timeout + 50);
    else             step = $urandom();
    now_ms = now_ms + step;
    send_report(id, zone, SPEED_W'(s), now_ms);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // map not loaded: ignored
    send_report(ID_MIN, 8'd1, 12'd4095, 32'd0);
    send_report(ID_ONES, 8'd255, 12'd0, 32'hffff_ffff);
    settle();
    configure(8'd30, 16'd500, 16'd1000, 1'b1);
    send_report(ID_ZERO, 8'd0, 12'd100, 32'd10);
    send_report(ID_MIN, 8'd1, 12'd4095, 32'd20);
    send_report(ID_MAX, 8'd255, 12'd0, 32'd30);
    send_report(ID_ONES, 8'd4, 12'd301, 32'd40);
    send_report(ID_MIN, 8'd0, 12'd500, 32'd100);       // erase inside snap window
    send_report(ID_MAX, 8'd0, 12'd4095, 32'd700);      // zone 0 kept, outside window
    send_report(ID_ZERO, 8'd3, 12'd300, 32'd710);      // exactly at the limit
    send_report(ID_ZERO, 8'd3, 12'd301, 32'd720);
    send_report(ID_ZERO, 8'd2, 12'd301, 32'd730);
    send_report(ID_MIN, 8'd2, 12'd4095, 32'hffff_ff00);
    send_report(ID_ONES, 8'd1, 12'd4095, 32'h0000_0010); // time wraps
    send_report(ID_MAX, 8'd0, 12'd1, 32'h0000_0020);
    settle();
    configure(8'd255, 16'd65535, 16'd0, 1'b1);
    send_report(ID_MIN, 8'd5, 12'd4095, 32'h20);
    send_report(ID_MIN, 8'd5, 12'd2550, 32'h20);
    send_report(ID_MIN, 8'd5, 12'd2551, 32'h20);
    settle();
    configure(8'd0, 16'd0, 16'd65535, 1'b1);
    send_report(ID_MIN, 8'd0, 12'd0, 32'h20);
    send_report(ID_MIN, 8'd7, 12'd1, 32'h21);
    send_report(ID_MIN, 8'd0, 12'd4095, 32'h22);
    send_report(ID_MIN, 8'd7, 12'd0, 32'h23);
    now_ms = 32'h100;

    for (int ph = 0; ph < 8; ph++) begin
      settle();
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 58; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 58; end
        default: begin send_idle_pct = 14; stall_pct = 14; end
      endcase
      case (ph)
        1: configure(8'd0, 16'd65535, 16'd65535, 1'b1);
        2: configure(8'd255, 16'd0, 16'd0, 1'b1);
        5: configure(8'($urandom_range(20, 60)), 16'($urandom_range(0, 2000)),
                     16'd65535, 1'b1);
        default: configure(8'($urandom_range(0, 255)), 16'($urandom()),
                           16'($urandom_range(100, 5000)), 1'b1);
      endcase
      // more ids than slots lets the table overflow
      pool_n = (ph == 1 || ph == 5) ? 48 : $urandom_range(3, 40);
      for (int i = 0; i < pool_n; i++) id_pool[i] = $urandom();
      id_pool[0] = ID_MIN;
      id_pool[1] = ID_MAX;
      repeat (112) random_report();
      if (ph == 3) begin
        settle();
        configure(8'(cur_limit), 16'(cur_snap), 16'(cur_timeout), 1'b0);
        repeat (6) random_report();
      end
    end

    settle();
    if (fail_count == 0)
      $display("speeding_vehicle_zone_tracker: match");
    else
      $display("speeding_vehicle_zone_tracker: mismatch");
    $finish;
  end

endmodule

FILE: sim.f
sv/svzt_pkg.sv
sv/svzt_ram.sv
sv/svzt_dp.sv
sv/svzt_ctrl.sv
sv/speeding_vehicle_zone_tracker.sv
sim/zone_sign_checker.sv
sim/speeding_vehicle_zone_tracker_tb.sv
